// ===== hw/rtl/brsg_pkg.sv =====
// Shared types and constants for the band ratio squelch gate.
// Sequencer states, mode and run codes, register indexes, log2 table.
// No dependencies.
`timescale 1ns / 1ps
package brsg_pkg;

	localparam int WIRE_W    = 40;
	localparam int POW_W     = 48;
	localparam int DB_PER_LOG2 = 197283;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MLO, ST_MHI, ST_MADD, ST_FIN, ST_SQ, ST_POW,
		ST_LOGLD, ST_NORM, ST_LOGMUL, ST_LOGSUM, ST_RATMUL, ST_RATIO,
		ST_LEARN, ST_DIV, ST_GATE, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {OP_BX, OP_A1, OP_A2} op_t;

	typedef enum logic [1:0] {RUN_OFF, RUN_LEARN, RUN_AUTO, RUN_FIXED} run_t;

	localparam logic [1:0] MODE_AUTO  = 2'd1;
	localparam logic [1:0] MODE_FIXED = 2'd2;

	typedef enum logic [2:0] {
		REG_GATE_MODE, REG_THRESHOLD, REG_HOLD, REG_BOOT,
		REG_LOCKOUT, REG_RELEASE, REG_SIG_COEFS, REG_NOISE_COEFS
	} reg_idx_t;

	// log2(1 + i/16) in Q.16
	localparam logic [16:0] LOG_TAB [17] = '{
		17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711,
		17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
		17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
	};

endpackage

// ===== hw/rtl/brsg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used for the learned floor mean. No dependencies.
`timescale 1ns / 1ps
module brsg_div #(
	parameter int NW = 35,
	parameter int DW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quot_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quot_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= fits ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/band_ratio_squelch_gate.sv =====
// Band ratio squelch gate: one request in, one result out. A new request is taken only
// after the previous sample's result is loaded into the output register. Each sample runs
// its biquad sections on one shared 25x25 multiplier, then the power updates and a log2
// per band with normalization; the sample that ends floor learning also waits on the divider.
// A stalled result holds the sequencer in emit until the output frees.
// Asynchronous active-low reset clears all filter, power and gate state.
`timescale 1ns / 1ps
module band_ratio_squelch_gate #(
	parameter int SMOOTH_SHIFT = 10,
	parameter int COUNT_WIDTH  = 20,
	parameter int COEF_WIDTH   = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// config write port
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_addr,
	input  logic [3*COEF_WIDTH-1:0] cfg_data,
	// input stream
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [15:0]             s_axis_tdata,   // [15:0] in_sample
	input  logic                    s_axis_tlast,   // block_end
	// output stream
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// [15:0] out_sample, [16] gate_open, [32:17] band_snr, [34:33] run_state,
	// [50:35] active_threshold_db, [51] lockout_flag, [55:52] zero
	output logic [55:0]             m_axis_tdata,
	output logic                    m_axis_tlast    // block_end_out
);

	localparam int CW    = COUNT_WIDTH;
	localparam int FRAC  = COEF_WIDTH - 2;
	localparam int ACC_W = COEF_WIDTH + 41;
	localparam int SUM_W = CW + 16;
	localparam int MAG_W = CW + 15;
	localparam int WW    = brsg_pkg::WIRE_W;
	localparam int PW    = brsg_pkg::POW_W;

	// saturate to the 40-bit section word
	function automatic logic signed [WW-1:0] sat_wire(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'({1'b0, {(WW-1){1'b1}}});
		lo = -hi - 1;
		if (v > hi)
			return {1'b0, {(WW-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(WW-1){1'b0}}};
		else
			return v[WW-1:0];
	endfunction

	// ---------------- config registers ----------------
	logic [1:0]                gate_mode_q;
	logic signed [15:0]        thr_reg_q;
	logic [CW-1:0]             hold_len_q;
	logic [CW-1:0]             boot_len_q;
	logic [CW-1:0]             lock_len_q;
	logic [CW-1:0]             rel_len_q;
	logic [3*COEF_WIDTH-1:0]   sig_coef_q;
	logic [3*COEF_WIDTH-1:0]   noi_coef_q;
	logic                      restart;

	assign restart = cfg_we && (brsg_pkg::reg_idx_t'(cfg_addr) == brsg_pkg::REG_GATE_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_mode_q <= '0;
			thr_reg_q   <= 16'sd768;
			hold_len_q  <= CW'(24000);
			boot_len_q  <= CW'(48000);
			lock_len_q  <= CW'(72000);
			rel_len_q   <= CW'(24000);
			sig_coef_q  <= '0;
			noi_coef_q  <= '0;
		end else if (cfg_we) begin
			unique case (brsg_pkg::reg_idx_t'(cfg_addr))
				brsg_pkg::REG_GATE_MODE:   gate_mode_q <= cfg_data[1:0];
				brsg_pkg::REG_THRESHOLD:   thr_reg_q   <= cfg_data[15:0];
				brsg_pkg::REG_HOLD:        hold_len_q  <= cfg_data[CW-1:0];
				brsg_pkg::REG_BOOT:        boot_len_q  <= cfg_data[CW-1:0];
				brsg_pkg::REG_LOCKOUT:     lock_len_q  <= cfg_data[CW-1:0];
				brsg_pkg::REG_RELEASE:     rel_len_q   <= cfg_data[CW-1:0];
				brsg_pkg::REG_SIG_COEFS:   sig_coef_q  <= cfg_data;
				brsg_pkg::REG_NOISE_COEFS: noi_coef_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	brsg_pkg::state_t state_q, state_d;
	brsg_pkg::op_t    op_q;
	logic [1:0]       sec_q;
	logic             lg_sel_q;

	// datapath registers
	logic [15:0]             in_q;
	logic                    last_q;
	brsg_pkg::run_t          cur_mode_q;
	logic signed [WW-1:0]    x_q;
	logic signed [WW-1:0]    xs_q;
	logic signed [WW-1:0]    y_q;
	logic signed [WW-1:0]    d0n_q;
	logic signed [WW-1:0]    dly_q [8];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] bx_q;
	logic signed [49:0]      mul_q;
	logic [PW-1:0]           sig_pow_q;
	logic [PW-1:0]           noi_pow_q;
	logic [PW-1:0]           m_q;
	logic [5:0]              e_q;
	logic [21:0]             lg_base_q;
	logic [21:0]             ls_q;
	logic [21:0]             ln_q;
	logic signed [15:0]      ratio_q;
	logic                    open_q;
	logic signed [16:0]      thr_q;
	logic                    neg_q;

	// gate state
	brsg_pkg::run_t          run_mode_q;
	logic signed [16:0]      learned_q;
	logic signed [SUM_W-1:0] learn_sum_q;
	logic [CW-1:0]           learn_cnt_q;
	logic [CW-1:0]           hold_q;
	logic [CW:0]             above_q;
	logic [CW:0]             below_q;
	logic                    lockout_q;

	// output register
	logic                    out_valid_q;
	logic [15:0]             out_sample_q;
	logic                    out_open_q;
	logic [15:0]             out_ratio_q;
	logic [1:0]              out_run_q;
	logic [15:0]             out_thr_q;
	logic                    out_lock_q;
	logic                    out_last_q;

	logic in_acc;
	logic out_free;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// ---------------- shared multiplier operands ----------------
	logic [3*COEF_WIDTH-1:0]      coef_reg;
	logic signed [COEF_WIDTH-1:0] coef;
	logic signed [WW-1:0]         opnd;
	logic [WW-1:0]                ymag;
	logic [23:0]                  mag_c;
	logic [3:0]                   lidx;
	logic [16:0]                  tdiff;
	logic signed [22:0]           ldiff;
	logic signed [24:0]           mul_a;
	logic signed [24:0]           mul_b;

	assign coef_reg = sec_q[1] ? noi_coef_q : sig_coef_q;
	assign opnd     = (op_q == brsg_pkg::OP_BX) ? x_q : y_q;
	assign ymag     = y_q[WW-1] ? WW'(-y_q) : WW'(y_q);
	assign mag_c    = (ymag > WW'(24'hFFFFFF)) ? 24'hFFFFFF : ymag[23:0];
	assign lidx     = m_q[46:43];
	assign tdiff    = brsg_pkg::LOG_TAB[{1'b0, lidx} + 5'd1] - brsg_pkg::LOG_TAB[lidx];
	assign ldiff    = $signed({1'b0, ls_q}) - $signed({1'b0, ln_q});

	always_comb begin
		case (op_q)
			brsg_pkg::OP_A1: coef = coef_reg[2*COEF_WIDTH-1:COEF_WIDTH];
			brsg_pkg::OP_A2: coef = coef_reg[3*COEF_WIDTH-1:2*COEF_WIDTH];
			default:         coef = coef_reg[COEF_WIDTH-1:0];
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			brsg_pkg::ST_MLO: begin
				mul_a = 25'(coef);
				mul_b = $signed({5'b0, opnd[19:0]});
			end
			brsg_pkg::ST_MHI: begin
				mul_a = 25'(coef);
				mul_b = 25'($signed(opnd[39:20]));
			end
			brsg_pkg::ST_SQ: begin
				mul_a = $signed({1'b0, mag_c});
				mul_b = $signed({1'b0, mag_c});
			end
			brsg_pkg::ST_LOGMUL: begin
				mul_a = $signed({8'b0, tdiff});
				mul_b = $signed({9'b0, m_q[42:27]});
			end
			brsg_pkg::ST_RATMUL: begin
				mul_a = 25'(ldiff);
				mul_b = 25'(brsg_pkg::DB_PER_LOG2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) mul_q <= mul_a * mul_b;

	// ---------------- section arithmetic ----------------
	logic signed [ACC_W-1:0] y_sum;
	logic signed [ACC_W-1:0] d0_sum;
	logic signed [ACC_W-1:0] d1_sum;
	assign y_sum  = (acc_q >>> FRAC) + ACC_W'(dly_q[0]);
	assign d0_sum = ((-acc_q) >>> FRAC) + ACC_W'(dly_q[1]);
	assign d1_sum = (-bx_q - acc_q) >>> FRAC;

	// power smoothing
	logic [PW-1:0] pow_cur;
	logic [PW:0]   pow_sum;
	logic [PW-1:0] pow_new;
	assign pow_cur = sec_q[1] ? noi_pow_q : sig_pow_q;
	assign pow_sum = {1'b0, pow_cur} - {1'b0, pow_cur >> SMOOTH_SHIFT}
		+ {1'b0, mul_q[PW-1:0] >> SMOOTH_SHIFT};
	assign pow_new = pow_sum[PW] ? {PW{1'b1}} : pow_sum[PW-1:0];

	// ratio from the scaled log difference
	logic signed [25:0] rat_full;
	logic signed [15:0] rat_sat;
	assign rat_full = 26'(mul_q >>> 24);
	assign rat_sat  = (rat_full > 26'sd32767) ? 16'sh7FFF :
		(rat_full < -26'sd32768) ? 16'sh8000 : rat_full[15:0];

	// ---------------- learning ----------------
	logic [CW-1:0]           target;
	logic [CW-1:0]           cnt_new;
	logic signed [SUM_W-1:0] sum_new;
	logic                    learn_done;
	logic [MAG_W-1:0]        sum_mag;
	logic                    div_busy;
	logic                    div_done;
	logic [MAG_W-1:0]        div_quot;
	logic [CW-1:0]           div_rem;
	logic signed [16:0]      mean;

	assign target     = (boot_len_q == '0) ? CW'(1) : boot_len_q;
	assign cnt_new    = learn_cnt_q + 1'b1;
	assign sum_new    = learn_sum_q + SUM_W'(ratio_q);
	assign learn_done = cnt_new >= target;
	assign sum_mag    = sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);
	assign mean       = neg_q ? -$signed(17'(div_quot) + 17'(div_rem != '0))
		: $signed(17'(div_quot));

	brsg_div #(.NW(MAG_W), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == brsg_pkg::ST_LEARN && learn_done),
		.dividend (sum_mag),
		.divisor  (target),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// ---------------- gate decision ----------------
	logic signed [16:0] thr_sel;
	logic               above;
	logic [CW:0]        above_nx;
	logic [CW:0]        below_nx;
	logic               lock_nx;
	logic [CW-1:0]      hold_eff;
	logic [CW-1:0]      hold_nx;
	logic               open_nx;

	always_comb begin
		case (cur_mode_q)
			brsg_pkg::RUN_AUTO:  thr_sel = learned_q;
			brsg_pkg::RUN_FIXED: thr_sel = 17'(thr_reg_q);
			default:             thr_sel = '0;
		endcase
		above    = 17'(ratio_q) > thr_sel;
		above_nx = above_q;
		below_nx = below_q;
		lock_nx  = lockout_q;
		if (lock_len_q != '0) begin
			if (above) begin
				above_nx = (&above_q) ? above_q : above_q + 1'b1;
				below_nx = '0;
				if (above_nx > {1'b0, lock_len_q})
					lock_nx = 1'b1;
			end else begin
				above_nx = '0;
				below_nx = (&below_q) ? below_q : below_q + 1'b1;
				if (below_nx >= {1'b0, rel_len_q})
					lock_nx = 1'b0;
			end
		end
		hold_eff = (above && !lock_nx) ? hold_len_q : hold_q;
		if (cur_mode_q == brsg_pkg::RUN_OFF) begin
			open_nx = 1'b1;
			hold_nx = hold_q;
		end else begin
			open_nx = hold_eff != '0;
			hold_nx = open_nx ? hold_eff - 1'b1 : hold_eff;
		end
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brsg_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = brsg_pkg::ST_MLO;
			brsg_pkg::ST_MLO:    state_d = brsg_pkg::ST_MHI;
			brsg_pkg::ST_MHI:    state_d = brsg_pkg::ST_MADD;
			brsg_pkg::ST_MADD:   state_d = brsg_pkg::ST_FIN;
			brsg_pkg::ST_FIN: begin
				if (op_q == brsg_pkg::OP_A2 && sec_q[0])
					state_d = brsg_pkg::ST_SQ;
				else
					state_d = brsg_pkg::ST_MLO;
			end
			brsg_pkg::ST_SQ:     state_d = brsg_pkg::ST_POW;
			brsg_pkg::ST_POW:
				state_d = (sec_q == 2'd3) ? brsg_pkg::ST_LOGLD : brsg_pkg::ST_MLO;
			brsg_pkg::ST_LOGLD:  state_d = brsg_pkg::ST_NORM;
			brsg_pkg::ST_NORM:   if (m_q[PW-1]) state_d = brsg_pkg::ST_LOGMUL;
			brsg_pkg::ST_LOGMUL: state_d = brsg_pkg::ST_LOGSUM;
			brsg_pkg::ST_LOGSUM:
				state_d = lg_sel_q ? brsg_pkg::ST_RATMUL : brsg_pkg::ST_LOGLD;
			brsg_pkg::ST_RATMUL: state_d = brsg_pkg::ST_RATIO;
			brsg_pkg::ST_RATIO:
				state_d = (cur_mode_q == brsg_pkg::RUN_LEARN) ? brsg_pkg::ST_LEARN
					: brsg_pkg::ST_GATE;
			brsg_pkg::ST_LEARN:
				state_d = learn_done ? brsg_pkg::ST_DIV : brsg_pkg::ST_EMIT;
			brsg_pkg::ST_DIV:    if (div_done) state_d = brsg_pkg::ST_EMIT;
			brsg_pkg::ST_GATE:   state_d = brsg_pkg::ST_EMIT;
			brsg_pkg::ST_EMIT:   if (out_free) state_d = brsg_pkg::ST_IDLE;
			default:             state_d = brsg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= brsg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- control and gate state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= brsg_pkg::OP_BX;
			sec_q       <= '0;
			lg_sel_q    <= 1'b0;
			for (int i = 0; i < 8; i++) dly_q[i] <= '0;
			sig_pow_q   <= '0;
			noi_pow_q   <= '0;
			run_mode_q  <= brsg_pkg::RUN_OFF;
			learned_q   <= '0;
			learn_sum_q <= '0;
			learn_cnt_q <= '0;
			hold_q      <= '0;
			above_q     <= '0;
			below_q     <= '0;
			lockout_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result stays until taken; emit loads it once the slot frees
			out_valid_q <= (out_valid_q && !m_axis_tready) ||
				(state_q == brsg_pkg::ST_EMIT && out_free);
			if (restart) begin
				run_mode_q  <= (cfg_data[1:0] == brsg_pkg::MODE_AUTO) ? brsg_pkg::RUN_LEARN :
					(cfg_data[1:0] == brsg_pkg::MODE_FIXED) ? brsg_pkg::RUN_FIXED :
					brsg_pkg::RUN_OFF;
				learned_q   <= '0;
				learn_sum_q <= '0;
				learn_cnt_q <= '0;
				hold_q      <= '0;
				above_q     <= '0;
				below_q     <= '0;
				lockout_q   <= 1'b0;
			end
			case (state_q)
				brsg_pkg::ST_IDLE: begin
					sec_q    <= '0;
					op_q     <= brsg_pkg::OP_BX;
					lg_sel_q <= 1'b0;
				end
				brsg_pkg::ST_FIN: begin
					case (op_q)
						brsg_pkg::OP_BX: op_q <= brsg_pkg::OP_A1;
						brsg_pkg::OP_A1: op_q <= brsg_pkg::OP_A2;
						default: begin
							op_q <= brsg_pkg::OP_BX;
							// rotate so the next section's pair sits at the head
							for (int i = 0; i < 6; i++) dly_q[i] <= dly_q[i+2];
							dly_q[6] <= d0n_q;
							dly_q[7] <= sat_wire(d1_sum);
							if (!sec_q[0])
								sec_q <= sec_q + 1'b1;
						end
					endcase
				end
				brsg_pkg::ST_POW: begin
					if (sec_q[1])
						noi_pow_q <= pow_new;
					else
						sig_pow_q <= pow_new;
					sec_q <= sec_q + 1'b1;
				end
				brsg_pkg::ST_LOGSUM: lg_sel_q <= 1'b1;
				brsg_pkg::ST_LEARN: begin
					learn_sum_q <= sum_new;
					learn_cnt_q <= cnt_new;
				end
				brsg_pkg::ST_DIV: begin
					if (div_done) begin
						learned_q  <= mean + 17'(thr_reg_q);
						run_mode_q <= brsg_pkg::RUN_AUTO;
					end
				end
				brsg_pkg::ST_GATE: begin
					above_q   <= above_nx;
					below_q   <= below_nx;
					lockout_q <= lock_nx;
					hold_q    <= hold_nx;
				end
				default: ;
			endcase
		end
	end

	// ---------------- datapath payload ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			brsg_pkg::ST_IDLE: begin
				if (in_acc) begin
					in_q       <= s_axis_tdata;
					last_q     <= s_axis_tlast;
					cur_mode_q <= run_mode_q;
					x_q        <= WW'($signed(s_axis_tdata)) <<< 8;
					xs_q       <= WW'($signed(s_axis_tdata)) <<< 8;
				end
			end
			brsg_pkg::ST_MHI:  acc_q <= ACC_W'(mul_q);
			brsg_pkg::ST_MADD: acc_q <= acc_q + (ACC_W'(mul_q) <<< 20);
			brsg_pkg::ST_FIN: begin
				case (op_q)
					brsg_pkg::OP_BX: begin
						bx_q <= acc_q;
						y_q  <= sat_wire(y_sum);
					end
					brsg_pkg::OP_A1: d0n_q <= sat_wire(d0_sum);
					default: if (!sec_q[0]) x_q <= y_q;
				endcase
			end
			brsg_pkg::ST_POW:   x_q <= xs_q;
			brsg_pkg::ST_LOGLD: begin
				m_q <= lg_sel_q ? ((noi_pow_q < PW'(65536)) ? PW'(65536) : noi_pow_q)
					: ((sig_pow_q < PW'(65536)) ? PW'(65536) : sig_pow_q);
				e_q <= 6'd47;
			end
			brsg_pkg::ST_NORM: begin
				if (!m_q[PW-1]) begin
					if (m_q[PW-1:PW-8] == '0) begin
						m_q <= m_q << 8;
						e_q <= e_q - 6'd8;
					end else begin
						m_q <= m_q << 1;
						e_q <= e_q - 6'd1;
					end
				end
			end
			brsg_pkg::ST_LOGMUL: lg_base_q <= {e_q, 16'b0} + 22'(brsg_pkg::LOG_TAB[lidx]);
			brsg_pkg::ST_LOGSUM: begin
				if (lg_sel_q)
					ln_q <= lg_base_q + 22'(mul_q[31:16]);
				else
					ls_q <= lg_base_q + 22'(mul_q[31:16]);
			end
			brsg_pkg::ST_RATIO: ratio_q <= rat_sat;
			brsg_pkg::ST_LEARN: begin
				open_q <= 1'b0;
				thr_q  <= '0;
				neg_q  <= sum_new[SUM_W-1];
			end
			brsg_pkg::ST_GATE: begin
				open_q <= open_nx;
				thr_q  <= thr_sel;
			end
			brsg_pkg::ST_EMIT: begin
				if (out_free) begin
					out_sample_q <= open_q ? in_q : '0;
					out_open_q   <= open_q;
					out_ratio_q  <= ratio_q;
					out_run_q    <= cur_mode_q;
					out_thr_q    <= (thr_q > 17'sd32767) ? 16'h7FFF :
						(thr_q < -17'sd32768) ? 16'h8000 : thr_q[15:0];
					out_lock_q   <= lockout_q;
					out_last_q   <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = state_q == brsg_pkg::ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_lock_q, out_thr_q, out_run_q, out_ratio_q,
		out_open_q, out_sample_q};
	assign m_axis_tlast  = out_last_q;

	// ---------------- assertions ----------------
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == brsg_pkg::ST_DIV)
		else $error("divider busy outside divide state");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("request taken while a sample is in flight");

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_we && !(state_q == brsg_pkg::ST_DIV && div_done)) |=> $stable(run_mode_q))
		else $error("run mode changed without a config write or learn end");

endmodule
